// ----- sv/dwm_pkg.sv -----
// ---------------------------------------------------------------------------
// dwm_pkg
// Shared types and constants of the decimal word machine core.
// ---------------------------------------------------------------------------
package dwm_pkg;

    localparam logic [63:0] FIELD_BASE = 64'd100000;
    localparam logic [16:0] START_RESET = 17'd100;

    // opcode field weight, first word whose opcode field exceeds halt,
    // and reciprocal of 3125 scaled by 2^41
    localparam logic [63:0] OPC_UNIT  = 64'd10000000000;
    localparam logic [63:0] OPC_LIMIT = 64'd140000000000;
    localparam logic [63:0] DEC_MAGIC = 64'd703687442;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_COPY = 4'd5;
    localparam logic [3:0] OP_RD   = 4'd7;
    localparam logic [3:0] OP_WR   = 4'd8;
    localparam logic [3:0] OP_BR   = 4'd9;
    localparam logic [3:0] OP_BRN  = 4'd10;
    localparam logic [3:0] OP_BRZ  = 4'd11;
    localparam logic [3:0] OP_BRP  = 4'd12;
    localparam logic [3:0] OP_HALT = 4'd13;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DEC1,
        S_DEC2,
        S_RDB,
        S_RDA,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- sv/dwm_ram.sv -----
// ---------------------------------------------------------------------------
// dwm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/dwm_div.sv -----
// ---------------------------------------------------------------------------
// dwm_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dwm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] trial;
    logic        fits;

    assign trial = {r_r, r_q[63]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], fits};
            r_r <= fits ? 64'(trial - {1'b0, r_d}) : trial[63:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- sv/decimal_word_machine_core.sv -----
// ---------------------------------------------------------------------------
// decimal_word_machine_core
// Stored-program machine with 64-bit words held in one synchronous RAM.
//
//   channel  direction  handshake                   payload
//   cfg      in         i_cfg_we                    i_cfg_wdata (start address)
//   in       in         i_in_valid / o_in_stall     req_type, load_address, ...
//   out      out        o_out_valid / i_out_stall   write_valid ... next_pc
//
// A new item is taken only after the previous one has passed to the output
// register; a step fetches, decodes, reads its operands and executes, a
// multiply adds partial products and a divide waits for the one-bit-per-cycle divider.
// Decimal fields are split by constant compares and a reciprocal multiply.
// After reset the RAM is cleared word by word from address 0; no transfer in.
// A result waits in the output register while the next item is taken.
// ---------------------------------------------------------------------------
module decimal_word_machine_core #(
    parameter int MEM_WORDS = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [16:0]        i_load_address,
    input  logic signed [63:0] i_load_word,
    input  logic signed [63:0] i_read_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_write_valid,
    output logic signed [63:0] o_write_value,
    output logic               o_read_used,
    output logic [1:0]         o_run_status,
    output logic [16:0]        o_next_pc
);
    import dwm_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    t_state r_state, n_state;

    logic [16:0]   r_start;
    logic [16:0]   r_pc, n_pc;
    logic          r_stopped, n_stopped;
    logic [1:0]    r_status, n_status;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    logic [63:0] r_rv, n_rv;
    logic [16:0] r_op1, n_op1;
    logic [16:0] r_op2, n_op2;
    logic [3:0]  r_opc, n_opc;
    logic [33:0] r_rem, n_rem;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic        r_neg, n_neg;
    logic [1:0]  r_mcnt, n_mcnt;
    logic [63:0] r_acc, n_acc;
    logic        r_wv, n_wv;
    logic [63:0] r_wval, n_wval;
    logic        r_ru, n_ru;

    logic        r_ov, n_ov;
    logic        r_owv, n_owv;
    logic [63:0] r_owval, n_owval;
    logic        r_oru, n_oru;
    logic [1:0]  r_ost, n_ost;
    logic [16:0] r_opc_out, n_opc_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    logic        div_start;
    logic [63:0] div_a;
    logic [63:0] div_b;
    logic        div_done;
    logic [63:0] div_q;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    logic        accept;
    logic [16:0] pc1;
    logic [3:0]  fetch_opc;
    logic [33:0] fetch_rem;
    logic [63:0] dec_prod;
    logic [33:0] dec_low;
    logic [16:0] dec_op2;
    logic        need1;
    logic        need2;

    function automatic logic addr_ok(input logic [16:0] a);
        return 32'(a) < 32'(MEM_WORDS);
    endfunction

    dwm_ram #(
        .WIDTH(64),
        .DEPTH(MEM_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    dwm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_a),
        .i_divisor (div_b),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    assign mul_x = (r_mcnt == 2'd2) ? r_a[63:32] : r_a[31:0];
    assign mul_y = (r_mcnt == 2'd1) ? r_b[63:32] : r_b[31:0];
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    // opcode field by constant compares; above halt the word is a no-op
    always_comb begin
        fetch_opc = OP_NOP;
        for (int k = 1; k <= int'(OP_HALT); k++) begin
            if (64'(ram_rdata[62:0]) >= 64'(k) * OPC_UNIT) begin
                fetch_opc = 4'(k);
            end
        end
        if (64'(ram_rdata[62:0]) >= OPC_LIMIT) begin
            fetch_opc = OP_NOP;
        end
    end

    assign fetch_rem = 34'(64'(ram_rdata[62:0]) - 64'(fetch_opc) * OPC_UNIT);
    assign dec_prod  = 64'(r_rem[33:5]) * DEC_MAGIC;
    assign dec_low   = r_rem - 34'(r_op1) * 34'(FIELD_BASE);
    assign dec_op2   = dec_low[16:0];

    assign o_in_stall = !(r_state == S_IDLE && !r_clr);
    assign accept     = i_in_valid && !o_in_stall;
    assign pc1        = r_pc + 17'd1;
    assign need1      = (r_opc >= OP_ADD && r_opc <= OP_COPY) ||
                        r_opc == OP_RD || r_opc == OP_WR;
    assign need2      = (r_opc >= OP_ADD && r_opc <= OP_COPY) ||
                        (r_opc >= OP_BRN && r_opc <= OP_BRP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= START_RESET;
            r_pc       <= START_RESET;
            r_stopped  <= 1'b1;
            r_status   <= ST_HALT;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_stopped <= n_stopped;
            r_status  <= n_status;
            r_ov      <= n_ov;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rv      <= n_rv;
        r_op1     <= n_op1;
        r_op2     <= n_op2;
        r_opc     <= n_opc;
        r_rem     <= n_rem;
        r_a       <= n_a;
        r_b       <= n_b;
        r_neg     <= n_neg;
        r_mcnt    <= n_mcnt;
        r_acc     <= n_acc;
        r_wv      <= n_wv;
        r_wval    <= n_wval;
        r_ru      <= n_ru;
        r_owv     <= n_owv;
        r_owval   <= n_owval;
        r_oru     <= n_oru;
        r_ost     <= n_ost;
        r_opc_out <= n_opc_out;
    end

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_stopped = r_stopped;
        n_status  = r_status;
        n_rv      = r_rv;
        n_op1     = r_op1;
        n_op2     = r_op2;
        n_opc     = r_opc;
        n_rem     = r_rem;
        n_a       = r_a;
        n_b       = r_b;
        n_neg     = r_neg;
        n_mcnt    = r_mcnt;
        n_acc     = r_acc;
        n_wv      = r_wv;
        n_wval    = r_wval;
        n_ru      = r_ru;
        n_ov      = r_ov && i_out_stall;
        n_owv     = r_owv;
        n_owval   = r_owval;
        n_oru     = r_oru;
        n_ost     = r_ost;
        n_opc_out = r_opc_out;
        ram_we    = r_clr;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        ram_raddr = r_pc[AW-1:0];
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wv    = 1'b0;
                    n_wval  = '0;
                    n_ru    = 1'b0;
                    n_rv    = i_read_value;
                    n_state = S_OUT;
                    unique case (i_req_type)
                        REQ_LOAD: begin
                            if (addr_ok(i_load_address)) begin
                                ram_we    = 1'b1;
                                ram_waddr = i_load_address[AW-1:0];
                                ram_wdata = i_load_word;
                            end
                        end
                        REQ_START: begin
                            n_pc      = r_start;
                            n_stopped = 1'b0;
                            n_status  = ST_RUN;
                        end
                        REQ_STEP: begin
                            if (!r_stopped) begin
                                if (!addr_ok(r_pc)) begin
                                    n_stopped = 1'b1;
                                    n_status  = ST_END;
                                end else begin
                                    n_state = S_FETCH;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                if (ram_rdata[63]) begin
                    n_pc = pc1;
                    if (!addr_ok(pc1)) begin
                        n_stopped = 1'b1;
                        n_status  = ST_END;
                    end
                    n_state = S_OUT;
                end else begin
                    n_opc   = fetch_opc;
                    n_rem   = fetch_rem;
                    n_state = S_DEC1;
                end
            end
            S_DEC1: begin
                n_op1   = dec_prod[57:41];
                n_state = S_DEC2;
            end
            S_DEC2: begin
                n_op2 = dec_op2;
                if ((need1 && !addr_ok(r_op1)) || (need2 && !addr_ok(dec_op2))) begin
                    n_stopped = 1'b1;
                    n_status  = ST_FAULT;
                    n_state   = S_OUT;
                end else begin
                    ram_raddr = dec_op2[AW-1:0];
                    n_state   = S_RDB;
                end
            end
            S_RDB: begin
                n_b       = ram_rdata;
                ram_raddr = r_op1[AW-1:0];
                n_state   = S_RDA;
            end
            S_RDA: begin
                n_a     = ram_rdata;
                n_mcnt  = '0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state   = S_OUT;
                ram_waddr = r_op1[AW-1:0];
                n_pc      = pc1;
                unique case (r_opc)
                    OP_ADD: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_a + r_b;
                    end
                    OP_SUB: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_a - r_b;
                    end
                    OP_MUL: begin
                        n_pc    = r_pc;
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        n_pc = r_pc;
                        if (r_b == '0) begin
                            n_stopped = 1'b1;
                            n_status  = ST_FAULT;
                        end else begin
                            div_start = 1'b1;
                            div_a     = r_a[63] ? 64'(-r_a) : r_a;
                            div_b     = r_b[63] ? 64'(-r_b) : r_b;
                            n_neg     = r_a[63] ^ r_b[63];
                            n_state   = S_DIV;
                        end
                    end
                    OP_COPY: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_b;
                    end
                    OP_RD: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_rv;
                        n_ru      = 1'b1;
                    end
                    OP_WR: begin
                        n_wv   = 1'b1;
                        n_wval = r_a;
                    end
                    OP_BR: n_pc = r_op1;
                    OP_BRN: if (r_b[63]) n_pc = r_op1;
                    OP_BRZ: if (r_b == '0) n_pc = r_op1;
                    OP_BRP: if (!r_b[63] && r_b != '0) n_pc = r_op1;
                    OP_HALT: begin
                        n_pc      = r_pc;
                        n_stopped = 1'b1;
                        n_status  = ST_HALT;
                    end
                    default: ;
                endcase
                if (n_state == S_OUT && !n_stopped && !addr_ok(n_pc)) begin
                    n_stopped = 1'b1;
                    n_status  = ST_END;
                end
            end
            S_MUL: begin
                n_mcnt = r_mcnt + 2'd1;
                if (r_mcnt == 2'd0) begin
                    n_acc = mul_p;
                end else begin
                    n_acc = r_acc + {mul_p[31:0], 32'd0};
                end
                if (r_mcnt == 2'd2) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_op1[AW-1:0];
                    ram_wdata = n_acc;
                    n_pc      = pc1;
                    if (!addr_ok(pc1)) begin
                        n_stopped = 1'b1;
                        n_status  = ST_END;
                    end
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_op1[AW-1:0];
                    ram_wdata = r_neg ? 64'(-div_q) : div_q;
                    n_pc      = pc1;
                    if (!addr_ok(pc1)) begin
                        n_stopped = 1'b1;
                        n_status  = ST_END;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov      = 1'b1;
                    n_owv     = r_wv;
                    n_owval   = r_wval;
                    n_oru     = r_ru;
                    n_ost     = r_status;
                    n_opc_out = r_pc;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid   = r_ov;
    assign o_write_valid = r_owv;
    assign o_write_value = r_owval;
    assign o_read_used   = r_oru;
    assign o_run_status  = r_ost;
    assign o_next_pc     = r_opc_out;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> o_in_stall) else $error("item taken during RAM clear");

    a_running_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stopped |-> r_status == ST_RUN) else $error("running with stop status");

    a_no_write_in_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC1 || r_state == S_DEC2 || r_state == S_RDB ||
         r_state == S_RDA) |-> !ram_we) else $error("RAM write during decode");

    a_wr_rd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_write_valid && o_read_used))
        else $error("write and read flagged together");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == S_FETCH || r_state == S_DEC1 ||
                       r_state == S_DEC2 || r_state == S_EXEC))
        else $error("divider started out of sequence");

endmodule

// ----- tb/decimal_word_machine_core_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_word_machine_core_checker
// Watches the request, result and start address ports of the machine,
// keeps its own copy of memory, program counter and status, and compares
// every result transfer with the oldest predicted one.
// ---------------------------------------------------------------------------
module decimal_word_machine_core_checker #(
    parameter int MEM_WORDS = 16384
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [16:0]        i_load_address,
    input  logic [63:0]        i_load_word,
    input  logic [63:0]        i_read_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_write_valid,
    input  logic [63:0]        i_write_value,
    input  logic               i_read_used,
    input  logic [1:0]         i_run_status,
    input  logic [16:0]        i_next_pc,
    output int                 o_mismatches,
    output int                 o_outstanding
);
    import dwm_pkg::*;

    typedef struct packed {
        logic        wr_valid;
        logic [63:0] wr_value;
        logic        rd_used;
        logic [1:0]  status;
        logic [16:0] pc;
    } t_step_result;

    t_step_result pending_results[$];

    logic [63:0] mem_copy [MEM_WORDS];
    logic [16:0] pc_copy;
    logic [16:0] start_copy;
    logic        stopped_copy;
    logic [1:0]  status_copy;

    function automatic logic [63:0] div_toward_zero(input logic [63:0] a,
                                                    input logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q  = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    task automatic stop_machine(input logic [1:0] st);
        stopped_copy = 1'b1;
        status_copy  = st;
    endtask

    task automatic jump_to(input logic [63:0] target);
        pc_copy = target[16:0];
        if (pc_copy >= MEM_WORDS)
            stop_machine(ST_END);
    endtask

    task automatic execute_word(input logic [63:0] rv, inout t_step_result r);
        logic [63:0] w;
        logic [63:0] opc;
        logic [63:0] op1;
        logic [63:0] op2;
        logic        need1;
        logic        need2;
        w = mem_copy[pc_copy];
        if (w[63]) begin
            jump_to(64'(pc_copy) + 64'd1);
            return;
        end
        op2 = w % FIELD_BASE;
        op1 = (w / FIELD_BASE) % FIELD_BASE;
        opc = w / (FIELD_BASE * FIELD_BASE);
        need1 = (opc >= OP_ADD && opc <= OP_COPY) || opc == OP_RD || opc == OP_WR;
        need2 = (opc >= OP_ADD && opc <= OP_COPY) || (opc >= OP_BRN && opc <= OP_BRP);
        if ((need1 && op1 >= MEM_WORDS) || (need2 && op2 >= MEM_WORDS)) begin
            stop_machine(ST_FAULT);
            return;
        end
        case (opc)
            OP_ADD:  mem_copy[op1] = mem_copy[op1] + mem_copy[op2];
            OP_SUB:  mem_copy[op1] = mem_copy[op1] - mem_copy[op2];
            OP_MUL:  mem_copy[op1] = mem_copy[op1] * mem_copy[op2];
            OP_DIV: begin
                if (mem_copy[op2] == 0) begin
                    stop_machine(ST_FAULT);
                    return;
                end
                mem_copy[op1] = div_toward_zero(mem_copy[op1], mem_copy[op2]);
            end
            OP_COPY: mem_copy[op1] = mem_copy[op2];
            OP_RD: begin
                mem_copy[op1] = rv;
                r.rd_used = 1'b1;
            end
            OP_WR: begin
                r.wr_valid = 1'b1;
                r.wr_value = mem_copy[op1];
            end
            OP_BR: begin
                jump_to(op1);
                return;
            end
            OP_BRN: if (mem_copy[op2][63]) begin
                jump_to(op1);
                return;
            end
            OP_BRZ: if (mem_copy[op2] == 0) begin
                jump_to(op1);
                return;
            end
            OP_BRP: if (!mem_copy[op2][63] && mem_copy[op2] != 0) begin
                jump_to(op1);
                return;
            end
            OP_HALT: begin
                stop_machine(ST_HALT);
                return;
            end
            default: ;
        endcase
        jump_to(64'(pc_copy) + 64'd1);
    endtask

    task automatic predict_request(input logic [1:0] rt, input logic [16:0] la,
                                   input logic [63:0] lw, input logic [63:0] rv);
        t_step_result r;
        r = '0;
        if (rt == REQ_LOAD) begin
            if (la < MEM_WORDS)
                mem_copy[la] = lw;
        end else if (rt == REQ_START) begin
            pc_copy      = start_copy;
            stopped_copy = 1'b0;
            status_copy  = ST_RUN;
        end else if (rt == REQ_STEP && !stopped_copy) begin
            if (pc_copy >= MEM_WORDS)
                stop_machine(ST_END);
            else
                execute_word(rv, r);
        end
        r.status = status_copy;
        r.pc     = pc_copy;
        pending_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_step_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++)
                mem_copy[i] = '0;
            start_copy   = START_RESET;
            pc_copy      = START_RESET;
            stopped_copy = 1'b1;
            status_copy  = ST_HALT;
            pending_results.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we)
                start_copy = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: result transfer with nothing predicted", $realtime);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.wr_valid !== i_write_valid || exp_r.wr_value !== i_write_value
                            || exp_r.rd_used !== i_read_used || exp_r.status !== i_run_status
                            || exp_r.pc !== i_next_pc) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("%0t: exp %0b %h %0b %0d %0d, got %0b %h %0b %0d %0d",
                                     $realtime, exp_r.wr_valid, exp_r.wr_value, exp_r.rd_used,
                                     exp_r.status, exp_r.pc, i_write_valid, i_write_value,
                                     i_read_used, i_run_status, i_next_pc);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_request(i_req_type, i_load_address, i_load_word, i_read_value);
        end
        o_outstanding = pending_results.size();
    end

endmodule

// ----- tb/decimal_word_machine_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_word_machine_core_test
// Loads small programs and data, starts and single-steps the machine with
// random start addresses, operands and input values, under bursty requests
// and a stalling receiver; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module decimal_word_machine_core_test;
    import dwm_pkg::*;

    localparam int MEM_WORDS = 16384;
    localparam int ITEM_TARGET = 1950;
    localparam logic [63:0] W_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] W_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [16:0] DATA_BASE = 17'd500;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [16:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_req_type;
    logic [16:0]        i_load_address;
    logic signed [63:0] i_load_word;
    logic signed [63:0] i_read_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_write_valid;
    logic signed [63:0] o_write_value;
    logic               o_read_used;
    logic [1:0]         o_run_status;
    logic [16:0]        o_next_pc;
    int                 mismatches;
    int                 outstanding;
    int                 items_sent;
    int                 burst_left;

    decimal_word_machine_core #(.MEM_WORDS(MEM_WORDS)) u_dut (.*);

    decimal_word_machine_core_checker #(.MEM_WORDS(MEM_WORDS)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_in_valid,
        .i_in_stall(o_in_stall), .i_req_type, .i_load_address, .i_load_word,
        .i_read_value, .i_out_valid(o_out_valid), .i_out_stall,
        .i_write_valid(o_write_valid), .i_write_value(o_write_value),
        .i_read_used(o_read_used), .i_run_status(o_run_status),
        .i_next_pc(o_next_pc), .o_mismatches(mismatches), .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("[decimal_word_machine_core] ERROR");
        $finish;
    end

    // receiver: changing stall patterns, two long hold-offs after the RAM clear
    initial begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 300 == 0)
                mode = $urandom_range(0, 3);
            if ((cyc >= 17500 && cyc < 19500) || (cyc >= 22000 && cyc < 23500))
                i_out_stall = 1'b1;
            else case (mode)
                0: i_out_stall = 1'b0;
                1: i_out_stall = $urandom_range(0, 1);
                2: i_out_stall = (cyc % 3 == 0);
                default: i_out_stall = ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    function automatic logic [63:0] encode(input int opc, input int op1, input int op2);
        return 64'(opc) * 64'd10000000000 + 64'(op1) * 64'd100000 + 64'(op2);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return W_MIN;
            4: return W_MAX;
            5: return 64'($urandom_range(0, 40)) - 64'd20;
            default: return rand_word();
        endcase
    endfunction

    task automatic send_request(input logic [1:0] rt, input logic [16:0] la,
                                input logic [63:0] lw, input logic [63:0] rv);
        logic stalled;
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_in_valid     = 1'b1;
        i_req_type     = rt;
        i_load_address = la;
        i_load_word    = lw;
        i_read_value   = rv;
        do begin
            #4;
            stalled = o_in_stall;
            @(negedge i_clk);
        end while (stalled);
        burst_left--;
        items_sent++;
    endtask

    task automatic load_word(input logic [16:0] a, input logic [63:0] w);
        send_request(REQ_LOAD, a, w, rand_word());
    endtask

    task automatic step_once();
        send_request(REQ_STEP, 17'($urandom), rand_word(), pick_data());
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    task automatic set_start(input logic [16:0] v);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic run_random_program();
        logic [16:0] s;
        int n;
        int opc;
        int op1;
        int op2;
        logic [16:0] extremes[6];
        extremes = '{17'd0, 17'd16383, 17'd16380, 17'd16384, 17'd99999, 17'h1FFFF};
        s = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, 300))
                                       : extremes[$urandom_range(0, 5)];
        set_start(s);
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                opc = $urandom_range(0, 15);
                if (opc == 14)
                    opc = OP_HALT;
                else if (opc == 15)
                    opc = $urandom_range(14, 99);
                op1 = DATA_BASE + $urandom_range(0, 7);
                op2 = DATA_BASE + $urandom_range(0, 7);
                if (opc >= OP_BR && opc <= OP_BRP)
                    op1 = s + $urandom_range(0, n);
                if ($urandom_range(0, 9) == 0)
                    op1 = $urandom_range(0, 99999);
                if ($urandom_range(0, 9) == 0)
                    op2 = $urandom_range(0, 99999);
                load_word(17'(s + i), encode(opc, op1, op2));
            end else begin
                load_word(17'(s + i), rand_word());
            end
        end
        for (int i = 0; i < 8; i++)
            if ($urandom_range(0, 2) != 0)
                load_word(17'(DATA_BASE + i), pick_data());
        send_request(REQ_START, 17'($urandom), rand_word(), rand_word());
        repeat ($urandom_range(8, 30)) begin
            case ($urandom_range(0, 19))
                0: send_request(REQ_NONE, 17'($urandom), rand_word(), rand_word());
                1: load_word(17'($urandom), rand_word());
                2: send_request(REQ_START, 17'($urandom), rand_word(), rand_word());
                default: step_once();
            endcase
        end
    endtask

    initial begin
        logic [63:0] prog[10];
        logic [16:0] addr[10];
        items_sent     = 0;
        burst_left     = 0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_LOAD;
        i_load_address = '0;
        i_load_word    = '0;
        i_read_value   = '0;
        i_rst_n        = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: ignored types and addresses, then each arithmetic edge
        send_request(REQ_NONE, '1, '1, '1);
        step_once();
        load_word(17'h1FFFF, W_MAX);
        load_word(17'd99999, W_MIN);
        load_word(DATA_BASE, W_MIN);
        load_word(DATA_BASE + 17'd1, '1);
        load_word(DATA_BASE + 17'd3, 64'd7);
        load_word(DATA_BASE + 17'd4, W_MAX);
        addr = '{100, 101, 102, 103, 104, 105, 106, 108, 110, 112};
        prog = '{encode(OP_DIV, 500, 501), '1, encode(OP_WR, 500, 0),
                 encode(OP_RD, 505, 0), encode(OP_ADD, 503, 504),
                 encode(OP_MUL, 503, 501), encode(OP_BRN, 108, 501),
                 encode(OP_BRZ, 110, 502), encode(OP_BRP, 112, 504),
                 encode(OP_DIV, 503, 502)};
        foreach (prog[i])
            load_word(addr[i], prog[i]);
        send_request(REQ_START, '0, '0, '0);
        repeat (11) step_once();

        while (items_sent < ITEM_TARGET)
            run_random_program();

        wait_drained();
        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[decimal_word_machine_core] OK");
        else
            $display("[decimal_word_machine_core] ERROR");
        $finish;
    end

endmodule

// ----- decimal_word_machine_core.f -----
sv/dwm_pkg.sv
sv/dwm_ram.sv
sv/dwm_div.sv
sv/decimal_word_machine_core.sv
tb/decimal_word_machine_core_checker.sv
tb/decimal_word_machine_core_test.sv
